[design/dga_pkg.sv]
// Shared types and constants for the DALI gear addressing block.
`timescale 1ns / 1ps
package dga_pkg;
  localparam logic [4:0] KindTerminate  = 5'd0;
  localparam logic [4:0] KindDtr0       = 5'd1;
  localparam logic [4:0] KindInitialise = 5'd2;
  localparam logic [4:0] KindRandomise  = 5'd3;
  localparam logic [4:0] KindCompare    = 5'd4;
  localparam logic [4:0] KindWithdraw   = 5'd5;
  localparam logic [4:0] KindSearchH    = 5'd6;
  localparam logic [4:0] KindSearchM    = 5'd7;
  localparam logic [4:0] KindSearchL    = 5'd8;
  localparam logic [4:0] KindProgram    = 5'd9;
  localparam logic [4:0] KindVerify     = 5'd10;
  localparam logic [4:0] KindQuery      = 5'd11;
  localparam logic [4:0] KindDtr1       = 5'd12;
  localparam logic [4:0] KindDtr2       = 5'd13;
  localparam logic [4:0] KindEnableType = 5'd14;
  localparam logic [4:0] KindTimeout    = 5'd15;
  localparam logic [4:0] KindLoad       = 5'd16;

  localparam logic [1:0] ModeDisabled  = 2'd0;
  localparam logic [1:0] ModeEnabled   = 2'd1;
  localparam logic [1:0] ModeWithdrawn = 2'd2;

  localparam logic [1:0] RegTimeout = 2'd0;
  localparam logic [1:0] RegUid0    = 2'd1;
  localparam logic [1:0] RegUid1    = 2'd2;
  localparam logic [1:0] RegUid2    = 2'd3;

  localparam logic [31:0] LcgMul = 32'd1103515245;
  localparam logic [31:0] LcgAdd = 32'd12345;
  localparam logic [31:0] TimeoutReset = 32'd900000;
  localparam logic [7:0]  NoShort = 8'hFF;
  localparam logic [23:0] Addr24Ones = 24'hFFFFFF;
  localparam int QueueDepth = 2;

  // Classified command handed from front to back.
  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  cmd_data;
    logic        repeat_ok;
    logic [31:0] now_ms;
    logic [31:0] seed;
    logic [23:0] random_load;
  } cmd_t;
endpackage

[design/dga_front.sv]
// Front end: accepts commands and precomputes the unmultiplied randomise seed.
`timescale 1ns / 1ps
module dga_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [4:0]         kind_i,
  input  logic [7:0]         cmd_data_i,
  input  logic               repeat_ok_i,
  input  logic [31:0]        now_ms_i,
  input  logic [31:0]        entropy_i,
  input  logic [7:0]         light_level_i,
  input  logic [23:0]        random_load_i,
  input  logic [31:0]        uid0_i,
  input  logic [31:0]        uid1_i,
  input  logic [31:0]        uid2_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dga_pkg::cmd_t      cmd_o
);
  dga_pkg::cmd_t mem_q [dga_pkg::QueueDepth];
  logic wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  dga_pkg::cmd_t c;
  logic push, pop;

  // The short address term of the seed is added in the back end, where the
  // short address is current when the transaction executes.
  always_comb begin
    c.kind = kind_i;
    c.cmd_data = cmd_data_i;
    c.repeat_ok = repeat_ok_i;
    c.now_ms = now_ms_i;
    c.random_load = random_load_i;
    c.seed = entropy_i ^ uid0_i ^ {uid1_i[24:0], uid1_i[31:25]}
           ^ {uid2_i[14:0], uid2_i[31:15]} ^ {16'd0, light_level_i, 8'd0};
  end

  assign ready_o = (cnt_q != 2'(dga_pkg::QueueDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;
  assign cmd_o = mem_q[rd_q];
  assign wr_d = push ? ~wr_q : wr_q;
  assign rd_d = pop ? ~rd_q : rd_q;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

[design/dga_back.sv]
// Back end: addressing state machine with a registered result.
`timescale 1ns / 1ps
module dga_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  dga_pkg::cmd_t cmd_i,
  input  logic [31:0]   timeout_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic          backward_valid_o,
  output logic [7:0]    backward_value_o,
  output logic          in_init_o,
  output logic [23:0]   random_address_o,
  output logic [7:0]    short_address_out_o,
  output logic          save_request_o,
  output logic [7:0]    dtr0_out_o,
  output logic [7:0]    dtr1_out_o,
  output logic [7:0]    dtr2_out_o,
  output logic [7:0]    device_type_out_o
);
  logic [1:0]  mode_q, mode_d;
  logic [31:0] start_q, start_d;
  logic [23:0] rnd_q, rnd_d, srch_q, srch_d;
  logic [7:0]  sa_q, sa_d, d0_q, d0_d, d1_q, d1_d, d2_q, d2_d, et_q, et_d;
  logic        ov_q, bv_q, bv_d, sv_q, sv_d;
  logic [7:0]  bval_q, bval_d;
  logic        en, match, take, hit;
  logic [5:0]  dec;
  logic [31:0] seed, prod, elapsed;

  assign ready_o = !ov_q || ready_i;
  assign take = valid_i && ready_o;
  assign en = (mode_q == dga_pkg::ModeEnabled);
  assign match = (rnd_q == srch_q);
  assign dec = cmd_i.cmd_data[6:1];
  assign seed = cmd_i.seed ^ {sa_q, 24'd0};
  assign prod = seed * dga_pkg::LcgMul + dga_pkg::LcgAdd;
  assign elapsed = cmd_i.now_ms - start_q;

  always_comb begin
    mode_d = mode_q; start_d = start_q; rnd_d = rnd_q; srch_d = srch_q;
    sa_d = sa_q; d0_d = d0_q; d1_d = d1_q; d2_d = d2_q; et_d = et_q;
    bv_d = 1'b0; bval_d = 8'd0; sv_d = 1'b0; hit = 1'b0;
    case (cmd_i.kind)
      dga_pkg::KindTerminate: mode_d = dga_pkg::ModeDisabled;
      dga_pkg::KindDtr0: d0_d = cmd_i.cmd_data;
      dga_pkg::KindInitialise: begin
        if (cmd_i.cmd_data == 8'h00) hit = 1'b1;
        else if (cmd_i.cmd_data == 8'hFF) hit = (sa_q == dga_pkg::NoShort);
        else if (cmd_i.cmd_data[0]) hit = ({2'b00, dec} == sa_q);
        if (cmd_i.repeat_ok && hit) begin
          mode_d = dga_pkg::ModeEnabled;
          start_d = cmd_i.now_ms;
        end
      end
      dga_pkg::KindRandomise: if (en && cmd_i.repeat_ok) begin
        rnd_d = prod[23:0];
        sv_d = 1'b1;
      end
      dga_pkg::KindCompare: if (en && rnd_q <= srch_q) begin
        bv_d = 1'b1; bval_d = 8'hFF;
      end
      dga_pkg::KindWithdraw: if (en && match) mode_d = dga_pkg::ModeWithdrawn;
      dga_pkg::KindSearchH: srch_d[23:16] = cmd_i.cmd_data;
      dga_pkg::KindSearchM: srch_d[15:8] = cmd_i.cmd_data;
      dga_pkg::KindSearchL: srch_d[7:0] = cmd_i.cmd_data;
      dga_pkg::KindProgram: if (en && match) begin
        sa_d = (cmd_i.cmd_data == 8'hFF) ? dga_pkg::NoShort : {2'b00, dec};
        sv_d = 1'b1;
      end
      dga_pkg::KindVerify: if (en && {2'b00, dec} == sa_q) begin
        bv_d = 1'b1; bval_d = 8'hFF;
      end
      dga_pkg::KindQuery: if (en && match) begin
        bv_d = 1'b1;
        bval_d = (sa_q == dga_pkg::NoShort) ? 8'hFF : {sa_q[6:0], 1'b1};
      end
      dga_pkg::KindDtr1: d1_d = cmd_i.cmd_data;
      dga_pkg::KindDtr2: d2_d = cmd_i.cmd_data;
      dga_pkg::KindEnableType: et_d = cmd_i.cmd_data;
      dga_pkg::KindTimeout:
        if (mode_q != dga_pkg::ModeDisabled && elapsed > timeout_i)
          mode_d = dga_pkg::ModeDisabled;
      dga_pkg::KindLoad: rnd_d = cmd_i.random_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dga_pkg::ModeDisabled; start_q <= 32'd0;
      rnd_q <= dga_pkg::Addr24Ones; srch_q <= dga_pkg::Addr24Ones;
      sa_q <= dga_pkg::NoShort; d0_q <= 8'd0; d1_q <= 8'd0; d2_q <= 8'd0;
      et_q <= 8'd0; ov_q <= 1'b0; bv_q <= 1'b0; bval_q <= 8'd0; sv_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q <= mode_d; start_q <= start_d; rnd_q <= rnd_d; srch_q <= srch_d;
        sa_q <= sa_d; d0_q <= d0_d; d1_q <= d1_d; d2_q <= d2_d; et_q <= et_d;
        bv_q <= bv_d; bval_q <= bval_d; sv_q <= sv_d;
        ov_q <= 1'b1;
      end else if (ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign valid_o = ov_q;
  assign backward_valid_o = bv_q;
  assign backward_value_o = bval_q;
  assign in_init_o = (mode_q == dga_pkg::ModeEnabled);
  assign random_address_o = rnd_q;
  assign short_address_out_o = sa_q;
  assign save_request_o = sv_q;
  assign dtr0_out_o = d0_q;
  assign dtr1_out_o = d1_q;
  assign dtr2_out_o = d2_q;
  assign device_type_out_o = et_q;
endmodule

[design/dali_gear_addressing.sv]
// Top level of the DALI control-gear addressing block.
// Path from input transaction to result: the queue, then the result register.
// Throughput: one transaction per cycle while the receiver holds ready_i high.
// The randomise multiply and the state update share the back-end cycle.
// Reset: asynchronous, active low; state and control registers take their defaults, the queue storage is not reset.
`timescale 1ns / 1ps
module dali_gear_addressing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [4:0]  kind_i,
  input  logic [7:0]  cmd_data_i,
  input  logic        repeat_ok_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] entropy_i,
  input  logic [7:0]  light_level_i,
  input  logic [23:0] random_load_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        backward_valid_o,
  output logic [7:0]  backward_value_o,
  output logic        in_init_o,
  output logic [23:0] random_address_o,
  output logic [7:0]  short_address_out_o,
  output logic        save_request_o,
  output logic [7:0]  dtr0_out_o,
  output logic [7:0]  dtr1_out_o,
  output logic [7:0]  dtr2_out_o,
  output logic [7:0]  device_type_out_o
);
  logic [31:0] tmo_q, u0_q, u1_q, u2_q;
  logic qv, qr;
  dga_pkg::cmd_t qc;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= dga_pkg::TimeoutReset;
      u0_q <= 32'd0; u1_q <= 32'd0; u2_q <= 32'd0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        dga_pkg::RegTimeout: tmo_q <= pwdata;
        dga_pkg::RegUid0:    u0_q <= pwdata;
        dga_pkg::RegUid1:    u1_q <= pwdata;
        dga_pkg::RegUid2:    u2_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dga_pkg::RegTimeout: prdata = tmo_q;
      dga_pkg::RegUid0:    prdata = u0_q;
      dga_pkg::RegUid1:    prdata = u1_q;
      default:             prdata = u2_q;
    endcase
  end

  dga_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .kind_i, .cmd_data_i, .repeat_ok_i,
    .now_ms_i, .entropy_i, .light_level_i, .random_load_i,
    .uid0_i(u0_q), .uid1_i(u1_q), .uid2_i(u2_q),
    .valid_o(qv), .ready_i(qr), .cmd_o(qc)
  );

  dga_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .ready_o(qr), .cmd_i(qc), .timeout_i(tmo_q),
    .valid_o, .ready_i, .backward_valid_o, .backward_value_o,
    .in_init_o, .random_address_o, .short_address_out_o, .save_request_o,
    .dtr0_out_o, .dtr1_out_o, .dtr2_out_o, .device_type_out_o
  );
endmodule

[dv/tb_dali_gear_addressing.sv]
// Self-checking testbench for the DALI gear addressing block with a built-in predictor.
`timescale 1ns / 1ps
module tb_dali_gear_addressing;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  cmd_data;
    logic        repeat_ok;
    logic [31:0] now_ms;
    logic [31:0] entropy;
    logic [7:0]  light_level;
    logic [23:0] random_load;
  } command_t;

  typedef struct packed {
    logic        bwd_valid;
    logic [7:0]  bwd_value;
    logic        in_init;
    logic [23:0] rand_addr;
    logic [7:0]  short_addr;
    logic        save;
    logic [7:0]  dtr0;
    logic [7:0]  dtr1;
    logic [7:0]  dtr2;
    logic [7:0]  dev_type;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic valid_i = 1'b0;
  logic ready_o;
  logic [4:0] kind_i = '0;
  logic [7:0] cmd_data_i = '0;
  logic repeat_ok_i = 1'b0;
  logic [31:0] now_ms_i = '0, entropy_i = '0;
  logic [7:0] light_level_i = '0;
  logic [23:0] random_load_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic backward_valid_o, in_init_o, save_request_o;
  logic [7:0] backward_value_o, short_address_out_o, dtr0_out_o, dtr1_out_o;
  logic [7:0] dtr2_out_o, device_type_out_o;
  logic [23:0] random_address_o;

  dali_gear_addressing u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and configuration copy.
  logic [31:0] cfg_timeout, cfg_uid0, cfg_uid1, cfg_uid2;
  logic [1:0]  gear_mode;
  logic [31:0] gear_init_start;
  logic [23:0] gear_random, gear_search;
  logic [7:0]  gear_short, gear_dtr0, gear_dtr1, gear_dtr2, gear_type;

  command_t pending_cmds[$];
  answer_t  expected_answers[$];
  int       mismatches = 0;
  int       send_idle_pct = 0, recv_stall_pct = 0;
  bit       hold_send = 1'b0;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic answer_t gear_step(input command_t c);
    answer_t a;
    logic enabled, match, hit;
    logic [5:0] dec;
    logic [31:0] seed;
    a = '0;
    enabled = (gear_mode == dga_pkg::ModeEnabled);
    match = (gear_random == gear_search);
    dec = c.cmd_data[6:1];
    case (c.kind)
      dga_pkg::KindTerminate: gear_mode = dga_pkg::ModeDisabled;
      dga_pkg::KindDtr0: gear_dtr0 = c.cmd_data;
      dga_pkg::KindInitialise: if (c.repeat_ok) begin
        if (c.cmd_data == 8'h00) hit = 1'b1;
        else if (c.cmd_data == 8'hFF) hit = (gear_short == dga_pkg::NoShort);
        else if (c.cmd_data[0]) hit = ({2'b00, dec} == gear_short);
        else hit = 1'b0;
        if (hit) begin
          gear_mode = dga_pkg::ModeEnabled;
          gear_init_start = c.now_ms;
        end
      end
      dga_pkg::KindRandomise: if (enabled && c.repeat_ok) begin
        seed = c.entropy ^ cfg_uid0 ^ rotl(cfg_uid1, 7) ^ rotl(cfg_uid2, 17);
        seed = seed ^ ({24'd0, gear_short} << 24) ^ ({24'd0, c.light_level} << 8);
        seed = seed * dga_pkg::LcgMul + dga_pkg::LcgAdd;
        gear_random = seed[23:0];
        a.save = 1'b1;
      end
      dga_pkg::KindCompare: if (enabled && gear_random <= gear_search) begin
        a.bwd_valid = 1'b1;
        a.bwd_value = 8'hFF;
      end
      dga_pkg::KindWithdraw: if (enabled && match) gear_mode = dga_pkg::ModeWithdrawn;
      dga_pkg::KindSearchH: gear_search[23:16] = c.cmd_data;
      dga_pkg::KindSearchM: gear_search[15:8] = c.cmd_data;
      dga_pkg::KindSearchL: gear_search[7:0] = c.cmd_data;
      dga_pkg::KindProgram: if (enabled && match) begin
        gear_short = (c.cmd_data == 8'hFF) ? dga_pkg::NoShort : {2'b00, dec};
        a.save = 1'b1;
      end
      dga_pkg::KindVerify: if (enabled && {2'b00, dec} == gear_short) begin
        a.bwd_valid = 1'b1;
        a.bwd_value = 8'hFF;
      end
      dga_pkg::KindQuery: if (enabled && match) begin
        a.bwd_valid = 1'b1;
        a.bwd_value = (gear_short == dga_pkg::NoShort) ? 8'hFF
                    : {gear_short[6:0], 1'b1};
      end
      dga_pkg::KindDtr1: gear_dtr1 = c.cmd_data;
      dga_pkg::KindDtr2: gear_dtr2 = c.cmd_data;
      dga_pkg::KindEnableType: gear_type = c.cmd_data;
      dga_pkg::KindTimeout:
        if (gear_mode != dga_pkg::ModeDisabled &&
            (c.now_ms - gear_init_start) > cfg_timeout)
          gear_mode = dga_pkg::ModeDisabled;
      dga_pkg::KindLoad: gear_random = c.random_load;
      default: ;
    endcase
    a.in_init = (gear_mode == dga_pkg::ModeEnabled);
    a.rand_addr = gear_random;
    a.short_addr = gear_short;
    a.dtr0 = gear_dtr0;
    a.dtr1 = gear_dtr1;
    a.dtr2 = gear_dtr2;
    a.dev_type = gear_type;
    return a;
  endfunction

  // Driver: present queued commands, predicting at acceptance.
  always @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      expected_answers.push_back(gear_step(pending_cmds.pop_front()));
    end
    if (!(valid_i && !ready_o)) begin
      if (pending_cmds.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        command_t n;
        n = pending_cmds[0];
        valid_i <= 1'b1;
        kind_i <= n.kind;
        cmd_data_i <= n.cmd_data;
        repeat_ok_i <= n.repeat_ok;
        now_ms_i <= n.now_ms;
        entropy_i <= n.entropy;
        light_level_i <= n.light_level;
        random_load_i <= n.random_load;
      end else begin
        valid_i <= 1'b0;
      end
    end
    ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      answer_t got, want;
      got = {backward_valid_o, backward_value_o, in_init_o, random_address_o,
             short_address_out_o, save_request_o, dtr0_out_o, dtr1_out_o,
             dtr2_out_o, device_type_out_o};
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %h", got);
      end else begin
        want = expected_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h, actual %h", want, got);
        end
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      dga_pkg::RegTimeout: cfg_timeout = val;
      dga_pkg::RegUid0: cfg_uid0 = val;
      dga_pkg::RegUid1: cfg_uid1 = val;
      default: cfg_uid2 = val;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || valid_i || expected_answers.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic command_t make_cmd(input logic [4:0] k, input logic [7:0] d,
                                        input logic r, input logic [31:0] t);
    command_t c;
    c.kind = k;
    c.cmd_data = d;
    c.repeat_ok = r;
    c.now_ms = t;
    c.entropy = $urandom;
    c.light_level = 8'($urandom);
    c.random_load = 24'($urandom);
    return c;
  endfunction

  // Picking the all-ones address or a small value as search address makes matches frequent.
  function automatic logic [23:0] gear_random_guess();
    return ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'($urandom_range(255));
  endfunction

  // Mostly well-formed search and program sequences with random content.
  task automatic push_random_batch(input int count, inout logic [31:0] clock_ms);
    command_t c;
    int n;
    logic [23:0] addr;
    n = 0;
    while (n < count) begin
      clock_ms = clock_ms + $urandom_range(3000);
      if ($urandom_range(9) < 7) begin
        addr = ($urandom_range(1) != 0) ? gear_random_guess() : 24'($urandom);
        pending_cmds.push_back(make_cmd(dga_pkg::KindInitialise,
          ($urandom_range(1) != 0) ? 8'h00 : 8'($urandom), 1'b1, clock_ms));
        pending_cmds.push_back(make_cmd(dga_pkg::KindRandomise, 8'h00,
          $urandom_range(3) != 0, clock_ms));
        pending_cmds.push_back(make_cmd(dga_pkg::KindSearchH, addr[23:16], 1'b0,
          clock_ms));
        pending_cmds.push_back(make_cmd(dga_pkg::KindSearchM, addr[15:8], 1'b0,
          clock_ms));
        pending_cmds.push_back(make_cmd(dga_pkg::KindSearchL, addr[7:0], 1'b0,
          clock_ms));
        pending_cmds.push_back(make_cmd(dga_pkg::KindCompare, 8'($urandom), 1'b0,
          clock_ms));
        pending_cmds.push_back(make_cmd(($urandom_range(1) != 0) ?
          dga_pkg::KindProgram : dga_pkg::KindQuery, 8'($urandom), 1'b0, clock_ms));
        pending_cmds.push_back(make_cmd(dga_pkg::KindVerify, 8'($urandom), 1'b0,
          clock_ms));
        n += 8;
      end else begin
        c = make_cmd(5'($urandom_range(31)), 8'($urandom), 1'($urandom), clock_ms);
        if ($urandom_range(3) == 0) c.now_ms = $urandom;
        pending_cmds.push_back(c);
        n += 1;
      end
    end
  endtask

  initial begin
    logic [31:0] clock_ms;
    int phase;
    cfg_timeout = dga_pkg::TimeoutReset;
    cfg_uid0 = '0;
    cfg_uid1 = '0;
    cfg_uid2 = '0;
    gear_mode = dga_pkg::ModeDisabled;
    gear_init_start = '0;
    gear_random = dga_pkg::Addr24Ones;
    gear_search = dga_pkg::Addr24Ones;
    gear_short = dga_pkg::NoShort;
    {gear_dtr0, gear_dtr1, gear_dtr2, gear_type} = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    clock_ms = 32'd100;

    // Directed part: every kind but the search kinds, two undefined kinds, and the named special cases.
    pending_cmds.push_back(make_cmd(dga_pkg::KindCompare, 8'h00, 1'b1, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindInitialise, 8'h00, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindInitialise, 8'h02, 1'b1, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindInitialise, 8'hFF, 1'b1, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindRandomise, 8'h00, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindRandomise, 8'hFF, 1'b1, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindCompare, 8'hFF, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindLoad, 8'h00, 1'b0, clock_ms));
    pending_cmds[$].random_load = 24'hFFFFFF;
    pending_cmds.push_back(make_cmd(dga_pkg::KindQuery, 8'h00, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindProgram, 8'hFF, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindProgram, 8'hFE, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindVerify, 8'h7F, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindQuery, 8'h00, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindInitialise, 8'hFF, 1'b1, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindInitialise, 8'hFF, 1'b1,
      clock_ms + 5));
    pending_cmds.push_back(make_cmd(dga_pkg::KindWithdraw, 8'h00, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindTimeout, 8'h00, 1'b0,
      clock_ms + 900005));
    pending_cmds.push_back(make_cmd(dga_pkg::KindTimeout, 8'h00, 1'b0,
      clock_ms + 900006));
    pending_cmds.push_back(make_cmd(dga_pkg::KindDtr0, 8'hFF, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindDtr1, 8'hAA, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindDtr2, 8'h55, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindEnableType, 8'h08, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(dga_pkg::KindTerminate, 8'h00, 1'b0, clock_ms));
    pending_cmds.push_back(make_cmd(5'd31, 8'hFF, 1'b1, 32'hFFFFFFFF));
    pending_cmds.push_back(make_cmd(5'd17, 8'h00, 1'b0, 32'd0));
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (phase)
        0: apb_write(dga_pkg::RegTimeout, 32'd0);
        1: apb_write(dga_pkg::RegTimeout, 32'hFFFFFFFF);
        2: apb_write(dga_pkg::RegTimeout, 32'($urandom_range(20000)));
        default: apb_write(dga_pkg::RegTimeout, 32'($urandom_range(5000)));
      endcase
      apb_write(dga_pkg::RegUid0, (phase == 1) ? 32'hFFFFFFFF : $urandom);
      apb_write(dga_pkg::RegUid1, (phase == 1) ? 32'hFFFFFFFF : $urandom);
      apb_write(dga_pkg::RegUid2, (phase == 0) ? 32'd0 : $urandom);
      push_random_batch(115, clock_ms);
      // Sender hold-off until the block has drained.
      hold_send = 1'b1;
      while (valid_i || expected_answers.size() != 0) @(posedge clk_i);
      hold_send = 1'b0;
      push_random_batch(115, clock_ms);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[files.f]
design/dga_pkg.sv
design/dga_front.sv
design/dga_back.sv
design/dali_gear_addressing.sv
dv/tb_dali_gear_addressing.sv
